// File: rtl/core/bitmap_frame_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit assertion macros
// Shared property forms for the allocator's checkers.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, codes and helper functions of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES  = 32768;
    localparam int FRAME_SHIFT = 12;
    localparam int WORD_BITS   = 32;
    localparam int LOG_WB      = $clog2(WORD_BITS);
    localparam int ADDR_OUT_W  = 27;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

    localparam logic [CFG_W-1:0] TOTAL_RST    = 16'd32768;
    localparam logic [CFG_W-1:0] RESERVED_RST = 16'd512;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TEST  = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] frame_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [ADDR_OUT_W-1:0] alloc_addr;
        logic                  occupied;
    } t_rsp;

    // bits below n set
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [LOG_WB:0] n);
        logic [WORD_BITS-1:0] m;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = (j < int'(n));
        end
        return m;
    endfunction

    // position of the lowest clear bit
    function automatic logic [LOG_WB-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] f;
        logic [WORD_BITS-1:0] l;
        logic [LOG_WB-1:0]    p;
        f = ~w;
        l = f & (~f + WORD_BITS'(1));
        p = '0;
        for (int b = 0; b < LOG_WB; b++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (((j >> b) & 1) == 1) begin
                    p[b] = p[b] | l[j];
                end
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/core/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Occupancy bitmap store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: bitmap sweep, first-fit scan and read-modify-write.
// ----------------------------------------------------------------------------
module bfa_ctrl #(
    parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES,
    parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT,
    localparam int WB     = bfa_pkg::WORD_BITS,
    localparam int LOG_WB = bfa_pkg::LOG_WB,
    localparam int NWORDS = (MAX_FRAMES + WB - 1) / WB,
    localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1,
    localparam int LIM_W  = $clog2(MAX_FRAMES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bfa_pkg::t_req     i_req,
    input  logic [LIM_W-1:0]  i_lim,
    input  logic [LIM_W-1:0]  i_rsv,
    output logic              o_busy,
    output logic              o_done,
    output bfa_pkg::t_rsp     o_rsp,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [WB-1:0]     o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [WB-1:0]     i_ram_rdata
);

    localparam int CNT_W = $clog2(NWORDS + 1);
    localparam int IDX_W = 32 - FRAME_SHIFT;
    localparam int AW    = ADDR_W + LOG_WB + FRAME_SHIFT + bfa_pkg::ADDR_OUT_W;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_MOD,
        S_SCAN
    } t_state;

    t_state              r_state;
    bfa_pkg::t_op        r_op;
    logic                r_init;
    logic [CNT_W-1:0]    r_word;
    logic [CNT_W-1:0]    r_chk;
    logic                r_have;
    logic [LOG_WB-1:0]   r_bit;
    logic                r_done;
    bfa_pkg::t_rsp       r_rsp;

    logic [IDX_W-1:0]    req_idx;
    logic                in_range;
    int                  last_w;
    logic [LOG_WB:0]     scan_n;
    logic [WB-1:0]       free_bits;
    logic                found;
    logic [LOG_WB-1:0]   fz_bit;
    logic [WB-1:0]       fz_one;
    logic [AW-1:0]       found_addr;
    logic [LOG_WB:0]     fill_n;
    int                  full_w;
    logic                accept;

    assign accept   = i_start && (r_state == S_IDLE);
    assign req_idx  = i_req.frame_addr[31:FRAME_SHIFT];
    assign in_range = (int'(req_idx) < int'(i_lim));
    assign last_w   = (int'(i_lim) - 1) >>> LOG_WB;

    always_comb begin
        if ((int'(r_chk) == last_w) && (i_lim[LOG_WB-1:0] != '0)) begin
            scan_n = {1'b0, i_lim[LOG_WB-1:0]};
        end else begin
            scan_n = (LOG_WB+1)'(WB);
        end
    end

    assign free_bits  = ~i_ram_rdata & bfa_pkg::low_mask(scan_n);
    assign found      = |free_bits;
    assign fz_bit     = bfa_pkg::first_zero(~free_bits);
    assign fz_one     = WB'(1) << fz_bit;
    assign found_addr = AW'({r_chk[ADDR_W-1:0], fz_bit}) << FRAME_SHIFT;

    assign full_w = int'(i_rsv) >> LOG_WB;

    always_comb begin
        if (!r_init) begin
            fill_n = '0;
        end else if (int'(r_word) < full_w) begin
            fill_n = (LOG_WB+1)'(WB);
        end else if (int'(r_word) == full_w) begin
            fill_n = {1'b0, i_rsv[LOG_WB-1:0]};
        end else begin
            fill_n = '0;
        end
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_word[ADDR_W-1:0];
        o_ram_wdata = bfa_pkg::low_mask(fill_n);
        o_ram_re    = 1'b0;
        o_ram_raddr = r_word[ADDR_W-1:0];
        unique case (r_state)
            S_FILL: begin
                o_ram_we = 1'b1;
            end
            S_READ: begin
                o_ram_re = 1'b1;
            end
            S_MOD: begin
                o_ram_we    = (r_op == bfa_pkg::OP_FREE);
                o_ram_wdata = i_ram_rdata & ~(WB'(1) << r_bit);
            end
            S_SCAN: begin
                o_ram_re    = (int'(r_word) <= last_w);
                o_ram_we    = r_have && found;
                o_ram_waddr = r_chk[ADDR_W-1:0];
                o_ram_wdata = i_ram_rdata | fz_one;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_init  <= 1'b0;
            r_word  <= '0;
            r_have  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_FILL: begin
                    r_word <= r_word + CNT_W'(1);
                    if (r_word == CNT_W'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                        if (r_init) begin
                            r_done            <= 1'b1;
                            r_rsp.status      <= bfa_pkg::ST_OK;
                            r_rsp.alloc_addr  <= '0;
                            r_rsp.occupied    <= 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= i_req.op;
                        r_bit  <= req_idx[LOG_WB-1:0];
                        r_have <= 1'b0;
                        r_rsp.alloc_addr <= '0;
                        r_rsp.occupied   <= 1'b0;
                        unique case (i_req.op)
                            bfa_pkg::OP_ALLOC: begin
                                r_word <= '0;
                                if (i_lim == '0) begin
                                    r_done       <= 1'b1;
                                    r_rsp.status <= bfa_pkg::ST_NO_FREE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            bfa_pkg::OP_FREE, bfa_pkg::OP_TEST: begin
                                r_word <= CNT_W'(req_idx >> LOG_WB);
                                if (in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_done       <= 1'b1;
                                    r_rsp.status <= bfa_pkg::ST_RANGE;
                                end
                            end
                            bfa_pkg::OP_INIT: begin
                                r_word  <= '0;
                                r_init  <= 1'b1;
                                r_state <= S_FILL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_done         <= 1'b1;
                    r_rsp.status   <= bfa_pkg::ST_OK;
                    r_rsp.occupied <= (r_op == bfa_pkg::OP_TEST) && i_ram_rdata[r_bit];
                    r_state        <= S_IDLE;
                end
                S_SCAN: begin
                    r_have <= o_ram_re;
                    r_chk  <= r_word;
                    if (o_ram_re) begin
                        r_word <= r_word + CNT_W'(1);
                    end
                    if (r_have && found) begin
                        r_done           <= 1'b1;
                        r_rsp.status     <= bfa_pkg::ST_OK;
                        r_rsp.alloc_addr <= found_addr[bfa_pkg::ADDR_OUT_W-1:0];
                        r_state          <= S_IDLE;
                    end else if (r_have && (int'(r_chk) == last_w)) begin
                        r_done       <= 1'b1;
                        r_rsp.status <= bfa_pkg::ST_NO_FREE;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// File: rtl/core/bitmap_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit physical frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// One request at a time: a transfer is taken when start is high and busy is
// low, and its single result appears on o_rsp for one cycle with o_done high;
// the receiver cannot stall it. The bitmap sits in one memory read one word a
// cycle, which sets the timing. Free and test read the frame's bitmap word,
// and free then writes it back with the frame's bit cleared; allocate scans
// the words in order from word zero up to the first with a free frame or the
// last word in the limit; init sweeps every word. A free or test out of range,
// and an allocate with a limit of zero, answer in the cycle after the transfer.
// After reset the block clears every bitmap word with busy high;
// configuration writes are taken at any time and should be made while idle.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
    parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES,
    parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bfa_pkg::t_req                 i_req,
    output logic                          o_done,
    output bfa_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int WB     = bfa_pkg::WORD_BITS;
    localparam int NWORDS = (MAX_FRAMES + WB - 1) / WB;
    localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LIM_W  = $clog2(MAX_FRAMES + 1);

    logic [bfa_pkg::CFG_W-1:0] r_total;
    logic [bfa_pkg::CFG_W-1:0] r_reserved;
    logic [LIM_W-1:0]          lim;
    logic [LIM_W-1:0]          rsv;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WB-1:0]     ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WB-1:0]     ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= bfa_pkg::TOTAL_RST;
            r_reserved <= bfa_pkg::RESERVED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfa_pkg::CFG_TOTAL:    r_total    <= i_cfg_data;
                bfa_pkg::CFG_RESERVED: r_reserved <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to capacity
    assign lim = (int'(r_total) > MAX_FRAMES) ? LIM_W'(MAX_FRAMES) : LIM_W'(r_total);
    assign rsv = (int'(r_reserved) > MAX_FRAMES) ? LIM_W'(MAX_FRAMES) : LIM_W'(r_reserved);

    bfa_ctrl #(
        .MAX_FRAMES  (MAX_FRAMES),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_lim       (lim),
        .i_rsv       (rsv),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    bfa_ram #(
        .DEPTH  (NWORDS),
        .WIDTH  (WB),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// File: rtl/core/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_unit_assert.svh"

module bfa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input bfa_pkg::t_req i_req,
    input logic          o_done,
    input bfa_pkg::t_rsp o_rsp
);

    `BFA_ASSERT_IMP(a_done_follows_work, i_clk, i_rst_n, o_done, $past(busy) || $past(start), "result without transfer")
    `BFA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, o_rsp.status == bfa_pkg::ST_OK || o_rsp.status == bfa_pkg::ST_NO_FREE || o_rsp.status == bfa_pkg::ST_RANGE, "bad status")
    `BFA_ASSERT_IMP(a_fail_clean, i_clk, i_rst_n, o_done && o_rsp.status != bfa_pkg::ST_OK, o_rsp.alloc_addr == '0 && !o_rsp.occupied, "failed result carries data")
    `BFA_ASSERT_NXT(a_init_sweeps, i_clk, i_rst_n, start && !busy && i_req.op == bfa_pkg::OP_INIT, busy, "init did not sweep")

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
